// ===== design/whsf_pkg.sv =====
// ----------------------------------------------------------------------------
// whsf_pkg: shared types, constants and tables for the waypoint steering block
// Holds payload structs, mode codes, register indexes and the CORDIC table.
// ----------------------------------------------------------------------------
`default_nettype none
package whsf_pkg;

  localparam int CordicItersDef = 16;
  localparam int AtanDepth      = 24;

  localparam logic [2:0] MODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_ACCEL  = 3'd1;
  localparam logic [2:0] MODE_BRAKE  = 3'd2;
  localparam logic [2:0] MODE_TURN   = 3'd3;
  localparam logic [2:0] MODE_CRUISE = 3'd4;

  localparam logic [2:0] REG_CRUISE    = 3'd0;
  localparam logic [2:0] REG_STEP      = 3'd1;
  localparam logic [2:0] REG_TURN      = 3'd2;
  localparam logic [2:0] REG_THRESH    = 3'd3;
  localparam logic [2:0] REG_TICK      = 3'd4;
  localparam logic [2:0] REG_START_X   = 3'd5;
  localparam logic [2:0] REG_START_Y   = 3'd6;
  localparam logic [2:0] REG_START_HDG = 3'd7;

  localparam logic [15:0] SPEED_EPS  = 16'd26;
  localparam logic [31:0] CORDIC_K   = 32'd652032874;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] at_x;
    logic signed [31:0] at_y;
    logic [15:0]        facing;
    logic [15:0]        velocity;
    logic [2:0]         mode_out;
  } out_item_t;

  // control from sequencer to the CORDIC engine
  typedef struct packed {
    logic       start;
    logic       vectoring;
  } cordic_ctl_t;

  function automatic logic [13:0] atan_lut(input logic [4:0] i);
    logic [13:0] r;
    case (i)
      5'd0:  r = 14'd8192;
      5'd1:  r = 14'd4836;
      5'd2:  r = 14'd2555;
      5'd3:  r = 14'd1297;
      5'd4:  r = 14'd651;
      5'd5:  r = 14'd326;
      5'd6:  r = 14'd163;
      5'd7:  r = 14'd81;
      5'd8:  r = 14'd41;
      5'd9:  r = 14'd20;
      5'd10: r = 14'd10;
      5'd11: r = 14'd5;
      5'd12: r = 14'd3;
      5'd13: r = 14'd1;
      5'd14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/whsf_cordic.sv =====
// ----------------------------------------------------------------------------
// whsf_cordic: shared iterative CORDIC, one micro-rotation per cycle
// Vectoring mode yields atan2 in binary angle; rotation mode yields cos/sin.
// ----------------------------------------------------------------------------
`default_nettype none
module whsf_cordic #(
  parameter int ITERS = whsf_pkg::CordicItersDef
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  whsf_pkg::cordic_ctl_t    ctl,
  input  wire signed [34:0]        x_in,
  input  wire signed [34:0]        y_in,
  input  wire signed [17:0]        z_in,
  output logic signed [34:0]       x_out,
  output logic signed [34:0]       y_out,
  output logic signed [17:0]       z_out,
  output logic                     done
);
  localparam int IW = $clog2(ITERS + 1);

  logic signed [34:0] x_r, y_r;
  logic signed [17:0] z_r;
  logic [IW-1:0]      it_r;
  logic               busy_r, vec_r, done_r;
  logic               dir_pos;
  logic signed [34:0] xs, ys;
  logic signed [17:0] a;

  // arithmetic shift floors, matching the model
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign a  = $signed({4'b0, whsf_pkg::atan_lut(5'(it_r))});
  assign dir_pos = vec_r ? (y_r >= 0) : (z_r >= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        vec_r  <= ctl.vectoring;
        it_r   <= '0;
        x_r    <= x_in;
        y_r    <= y_in;
        z_r    <= z_in;
      end else if (busy_r) begin
        if (dir_pos) begin
          x_r <= vec_r ? x_r + ys : x_r - ys;
          y_r <= vec_r ? y_r - xs : y_r + xs;
          z_r <= vec_r ? z_r + a  : z_r - a;
        end else begin
          x_r <= vec_r ? x_r - ys : x_r + ys;
          y_r <= vec_r ? y_r + xs : y_r - xs;
          z_r <= vec_r ? z_r - a  : z_r + a;
        end
        if (it_r == IW'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        it_r <= it_r + 1'b1;
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = done_r;
endmodule
`default_nettype wire

// ===== design/waypoint_heading_speed_fsm.sv =====
// ----------------------------------------------------------------------------
// waypoint_heading_speed_fsm: per-tick steering and speed controller
// Bearing by CORDIC atan2, mode choice, speed/heading update, then position
// advance along CORDIC cos/sin with rounding and saturation, unless turning in place.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | whsf_pkg::in_item_t (goal_x, goal_y)
// out_    | output    | out_valid/out_ready| whsf_pkg::out_item_t
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index [2:0], cfg_data [31:0]
//
// The shared CORDIC engine is used once in vectoring and once in rotation mode
// for each item, followed by the X and Y multiply steps. Turning in place skips
// the rotation pass and the multiplies. One item is in flight at a time;
// in_ready is low meanwhile and comes back the cycle after the result is taken.
// Reset (synchronous, rst_n low) loads register defaults and clears position,
// heading, mode and speed. A stalled result holds in the output register until
// out_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module waypoint_heading_speed_fsm #(
  parameter int CORDIC_ITERS = whsf_pkg::CordicItersDef
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  whsf_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output whsf_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [2:0]            cfg_index,
  input  wire  [31:0]           cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VEC  = 4'd1;
  localparam logic [3:0] S_VWT  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_RWT  = 4'd5;
  localparam logic [3:0] S_MULX = 4'd6;
  localparam logic [3:0] S_MULY = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] st_r;
  logic [15:0] cruise_r, sstep_r, tstep_r, thresh_r, tick_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [15:0] heading_r, speed_r, bearing_r;
  logic [2:0]  mode_r;
  logic signed [32:0] dx_r, dy_r;
  logic [31:0]        spd_tick_r;
  logic signed [31:0] cos_r, sin_r;
  logic               flip_r;
  logic               outv_r;
  whsf_pkg::out_item_t out_r;

  whsf_pkg::cordic_ctl_t ctl;
  logic signed [34:0] cx_in, cy_in, cx, cy;
  logic signed [17:0] cz_in, cz;
  logic               cdone;

  whsf_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk, .rst_n, .ctl, .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .x_out(cx), .y_out(cy), .z_out(cz), .done(cdone)
  );

  // decision logic on bearing
  logic [15:0] err16, mag;
  logic        err_neg, zero_vec;
  logic [15:0] d_turn;
  logic [16:0] acc_sum;
  logic [16:0] cruise_lim;
  assign err16   = bearing_r - heading_r;
  assign err_neg = err16[15];
  assign mag     = err_neg ? 16'(-err16) : err16;
  assign d_turn  = ({1'b0, mag} < {1'b0, tstep_r}) ? mag : tstep_r;
  assign acc_sum = {1'b0, speed_r} + {1'b0, sstep_r};
  assign cruise_lim = {1'b0, cruise_r} - {1'b0, whsf_pkg::SPEED_EPS};
  assign zero_vec = (dx_r == 0) && (dy_r == 0);

  // rotation angle fold
  logic [15:0] hnew;
  logic        fold_flip;
  logic signed [17:0] zfold;
  always_comb begin
    hnew = heading_r;
    fold_flip = 1'b0;
    if (hnew >= 16'd16384 && hnew < 16'd49152) begin
      zfold = $signed({2'b0, hnew}) - 18'sd32768;
      fold_flip = 1'b1;
    end else if (hnew >= 16'd49152) begin
      zfold = $signed({2'b0, hnew}) - 18'sd65536;
    end else begin
      zfold = $signed({2'b0, hnew});
    end
  end

  always_comb begin
    ctl = '0;
    cx_in = '0; cy_in = '0; cz_in = '0;
    if (st_r == S_VEC) begin
      ctl.start = 1'b1;
      ctl.vectoring = 1'b1;
      cx_in = dx_r[32] ? -35'(dx_r) : 35'(dx_r);
      cy_in = dx_r[32] ? -35'(dy_r) : 35'(dy_r);
      cz_in = dx_r[32] ? 18'sd32768 : 18'sd0;
    end else if (st_r == S_ROT) begin
      ctl.start = 1'b1;
      cx_in = 35'($signed({1'b0, whsf_pkg::CORDIC_K}));
      cz_in = zfold;
    end
  end

  // one shared 32x33 multiply; speed*tick is unsigned and may exceed 2^31
  logic signed [31:0] mul_a;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [33:0] disp, psum;
  logic signed [31:0] pold, psat;
  assign mul_a = (st_r == S_MULX) ? cos_r : sin_r;
  assign prod  = mul_a * $signed({1'b0, spd_tick_r});
  assign rnd   = prod + (64'sd1 <<< 37);
  assign disp  = 34'(rnd >>> 38);
  assign pold  = (st_r == S_MULX) ? pos_x_r : pos_y_r;
  assign psum  = 34'(pold) + disp;
  assign psat  = (psum > 34'sd2147483647) ? 32'sh7fffffff :
                 (psum < -34'sd2147483648) ? 32'sh80000000 : 32'(psum);

  assign in_ready  = (st_r == S_IDLE) && !outv_r;
  assign cfg_ready = 1'b1;
  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      outv_r <= 1'b0;
      cruise_r <= 16'd5120; sstep_r <= 16'd256; tstep_r <= 16'd104;
      thresh_r <= 16'd1043; tick_r <= 16'd655;
      pos_x_r <= '0; pos_y_r <= '0; heading_r <= '0;
      speed_r <= '0; mode_r <= whsf_pkg::MODE_STOP;
    end else begin
      if (outv_r && out_ready) outv_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          whsf_pkg::REG_CRUISE:    cruise_r <= cfg_data[15:0];
          whsf_pkg::REG_STEP:      sstep_r  <= cfg_data[15:0];
          whsf_pkg::REG_TURN:      tstep_r  <= cfg_data[15:0];
          whsf_pkg::REG_THRESH:    thresh_r <= cfg_data[15:0];
          whsf_pkg::REG_TICK:      tick_r   <= cfg_data[15:0];
          whsf_pkg::REG_START_X:   pos_x_r  <= cfg_data;
          whsf_pkg::REG_START_Y:   pos_y_r  <= cfg_data;
          whsf_pkg::REG_START_HDG: heading_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dx_r <= 33'(in_data.goal_x) - 33'(pos_x_r);
            dy_r <= 33'(in_data.goal_y) - 33'(pos_y_r);
            st_r <= S_VEC;
          end
        end
        S_VEC: st_r <= S_VWT;
        S_VWT: begin
          if (cdone) begin
            bearing_r <= zero_vec ? 16'd0 : cz[15:0];
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          // pick the mode and update speed / heading
          if (mag > thresh_r) begin
            if (speed_r > whsf_pkg::SPEED_EPS) begin
              mode_r  <= whsf_pkg::MODE_BRAKE;
              speed_r <= (speed_r > sstep_r) ? speed_r - sstep_r : 16'd0;
              st_r    <= S_ROT;
            end else begin
              mode_r    <= whsf_pkg::MODE_TURN;
              heading_r <= err_neg ? heading_r - d_turn : heading_r + d_turn;
              st_r      <= S_OUT;
            end
          end else if ($signed({1'b0, speed_r}) < $signed(cruise_lim)) begin
            mode_r  <= whsf_pkg::MODE_ACCEL;
            speed_r <= (acc_sum < {1'b0, cruise_r}) ? acc_sum[15:0] : cruise_r;
            st_r    <= S_ROT;
          end else begin
            mode_r    <= whsf_pkg::MODE_CRUISE;
            heading_r <= bearing_r;
            speed_r   <= cruise_r;
            st_r      <= S_ROT;
          end
        end
        S_ROT: begin
          flip_r     <= fold_flip;
          spd_tick_r <= speed_r * tick_r;
          st_r       <= S_RWT;
        end
        S_RWT: begin
          if (cdone) begin
            cos_r <= flip_r ? 32'(-cx) : 32'(cx);
            sin_r <= flip_r ? 32'(-cy) : 32'(cy);
            st_r  <= S_MULX;
          end
        end
        S_MULX: begin
          pos_x_r <= psat;
          st_r    <= S_MULY;
        end
        S_MULY: begin
          pos_y_r <= psat;
          st_r    <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!outv_r || out_ready) begin
            out_r.at_x     <= pos_x_r;
            out_r.at_y     <= pos_y_r;
            out_r.facing   <= heading_r;
            out_r.velocity <= speed_r;
            out_r.mode_out <= mode_r;
            outv_r <= 1'b1;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/whsf_checker.sv =====
// ----------------------------------------------------------------------------
// whsf_checker: port-level checks for the waypoint steering block
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module whsf_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input whsf_pkg::out_item_t  out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_out <= whsf_pkg::MODE_CRUISE)
    else $error("bad mode code");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");
  a_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open with a pending result");
  a_turn_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode_out == whsf_pkg::MODE_TURN |->
      out_data.velocity <= whsf_pkg::SPEED_EPS)
    else $error("turning in place at speed");
endmodule

bind waypoint_heading_speed_fsm whsf_checker u_whsf_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire
